// ===== hdl/hrs_pkg.sv =====
// Shared constants, types and the pixel address function of the region shrink step.
`default_nettype none
package hrs_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam int COORD_W  = 9;
    localparam int DIR_W    = 3;
    localparam int CMD_W    = 2;
    localparam int CONE_W   = 36;
    localparam int OFF_W    = 32;
    localparam int NCAND    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONE_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONE_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd4;

    typedef struct packed {
        logic [DIR_W-1:0] dir;
        logic             obj;
        logic             vis;
    } t_pix;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_pix              wdata;
    } t_mem_req;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               in_img;
        logic [ADDR_W-1:0]  addr;
    } t_nbr;

    // Column-major linear address of a 1-based pixel.
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
        logic [31:0] lin;
        lin = (32'(c) - 32'd1) * 32'(MAX_ROWS) + (32'(r) - 32'd1);
        return lin[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/halo_region_shrink_step.sv =====
// Output valid is set from S_DONE: a load or rejected item goes there straight from idle, a
// read or skipped process passes S_PIX first, and a processed pixel passes S_PIX and S_NBR.
// The input stalls until the last item has left S_DONE. The steps are set by the single pixel
// memory port: one pixel read, three neighbor object reads and one visited write-back.
// Synchronous active-low reset restores the registers to 256, 256, 0, 0, 0 and empties the
// pipeline; the pixel memory is not cleared and must be loaded before it is read.
`default_nettype none
module halo_region_shrink_step (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [hrs_pkg::CMD_W-1:0]          i_command,
    input  wire logic [hrs_pkg::COORD_W-1:0]        i_row,
    input  wire logic [hrs_pkg::COORD_W-1:0]        i_col,
    input  wire logic [hrs_pkg::DIR_W-1:0]          i_direction_in,
    input  wire logic                               i_object_in,
    input  wire logic                               i_visited_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [hrs_pkg::COORD_W-1:0]             o_cand0_row,
    output logic [hrs_pkg::COORD_W-1:0]             o_cand0_col,
    output logic                                    o_cand0_valid,
    output logic [hrs_pkg::COORD_W-1:0]             o_cand1_row,
    output logic [hrs_pkg::COORD_W-1:0]             o_cand1_col,
    output logic                                    o_cand1_valid,
    output logic [hrs_pkg::COORD_W-1:0]             o_cand2_row,
    output logic [hrs_pkg::COORD_W-1:0]             o_cand2_col,
    output logic                                    o_cand2_valid,
    output logic                                    o_remove_flag,
    output logic                                    o_visited_out,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [hrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hrs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_PIX, S_NBR, S_DONE} t_state;

    t_state r_state;

    logic [hrs_pkg::COORD_W-1:0] r_image_rows;
    logic [hrs_pkg::COORD_W-1:0] r_image_cols;
    logic [hrs_pkg::CONE_W-1:0]  r_cone_low;
    logic [hrs_pkg::CONE_W-1:0]  r_cone_high;
    logic [hrs_pkg::OFF_W-1:0]   r_offset;

    logic [hrs_pkg::CMD_W-1:0]   r_cmd;
    logic [hrs_pkg::COORD_W-1:0] r_row;
    logic [hrs_pkg::COORD_W-1:0] r_col;
    logic [hrs_pkg::DIR_W-1:0]   r_dir;
    logic                        r_obj;
    logic                        r_vis_res;
    logic [1:0]                  r_k;
    logic                        r_pend_in;
    logic [hrs_pkg::COORD_W-1:0] r_cand_row [hrs_pkg::NCAND];
    logic [hrs_pkg::COORD_W-1:0] r_cand_col [hrs_pkg::NCAND];
    logic [hrs_pkg::NCAND-1:0]   r_cand_valid;

    logic                        r_out_valid;

    logic [hrs_pkg::COORD_W-1:0] rows_eff;
    logic [hrs_pkg::COORD_W-1:0] cols_eff;
    logic                        in_acc;
    logic                        addr_ok;
    logic                        proc_ok;
    hrs_pkg::t_mem_req           mem_req;
    hrs_pkg::t_pix               mem_rdata;
    hrs_pkg::t_nbr               nbr;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign rows_eff = (32'(r_image_rows) > hrs_pkg::MAX_ROWS) ?
                      hrs_pkg::COORD_W'(hrs_pkg::MAX_ROWS) : r_image_rows;
    assign cols_eff = (32'(r_image_cols) > hrs_pkg::MAX_COLS) ?
                      hrs_pkg::COORD_W'(hrs_pkg::MAX_COLS) : r_image_cols;

    assign addr_ok = (i_row != '0) && (32'(i_row) <= hrs_pkg::MAX_ROWS) &&
                     (i_col != '0) && (32'(i_col) <= hrs_pkg::MAX_COLS);

    // Pixel must be unvisited and strictly inside the image.
    assign proc_ok = !mem_rdata.vis && (r_row > 9'd1) && (r_col > 9'd1) &&
                     (r_row < rows_eff) && (r_col < cols_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows <= 9'd256;
            r_image_cols <= 9'd256;
            r_cone_low   <= '0;
            r_cone_high  <= '0;
            r_offset     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hrs_pkg::CFG_IMAGE_ROWS: r_image_rows <= i_cfg_data[hrs_pkg::COORD_W-1:0];
                hrs_pkg::CFG_IMAGE_COLS: r_image_cols <= i_cfg_data[hrs_pkg::COORD_W-1:0];
                hrs_pkg::CFG_CONE_LOW:   r_cone_low   <= i_cfg_data[hrs_pkg::CONE_W-1:0];
                hrs_pkg::CFG_CONE_HIGH:  r_cone_high  <= i_cfg_data[hrs_pkg::CONE_W-1:0];
                hrs_pkg::CFG_OFFSET:     r_offset     <= i_cfg_data[hrs_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    hrs_nbr u_nbr (
        .i_row       (r_row),
        .i_col       (r_col),
        .i_dir       (r_dir),
        .i_slot      (r_k),
        .i_cone_low  (r_cone_low),
        .i_cone_high (r_cone_high),
        .i_offset    (r_offset),
        .i_rows      (rows_eff),
        .i_cols      (cols_eff),
        .o_nbr       (nbr)
    );

    always_comb begin
        mem_req       = '0;
        mem_req.addr  = hrs_pkg::pix_addr(i_row, i_col);
        case (r_state)
            S_IDLE: begin
                if (in_acc && addr_ok && i_command == hrs_pkg::CMD_LOAD) begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = '{dir: i_direction_in, obj: i_object_in, vis: i_visited_in};
                end
            end
            S_NBR: begin
                if (r_k != 2'd3) begin
                    mem_req.addr = nbr.addr;
                end else begin
                    // All neighbor reads are issued; write the visited mark back.
                    mem_req.we    = 1'b1;
                    mem_req.addr  = hrs_pkg::pix_addr(r_row, r_col);
                    mem_req.wdata = '{dir: r_dir, obj: r_obj, vis: 1'b1};
                end
            end
            default: ;
        endcase
    end

    hrs_pixmem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd        <= i_command;
                        r_row        <= i_row;
                        r_col        <= i_col;
                        r_cand_valid <= '0;
                        for (int i = 0; i < hrs_pkg::NCAND; i++) begin
                            r_cand_row[i] <= '0;
                            r_cand_col[i] <= '0;
                        end
                        if (!addr_ok || i_command == hrs_pkg::CMD_UNUSED) begin
                            r_vis_res <= 1'b0;
                            r_state   <= S_DONE;
                        end else if (i_command == hrs_pkg::CMD_LOAD) begin
                            r_vis_res <= i_visited_in;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_PIX;
                        end
                    end
                end
                S_PIX: begin
                    r_dir     <= mem_rdata.dir;
                    r_obj     <= mem_rdata.obj;
                    r_k       <= '0;
                    if (r_cmd == hrs_pkg::CMD_PROCESS && proc_ok) begin
                        r_vis_res <= 1'b1;
                        r_state   <= S_NBR;
                    end else begin
                        r_vis_res <= mem_rdata.vis;
                        r_state   <= S_DONE;
                    end
                end
                S_NBR: begin
                    // Issue slot r_k, capture the object bit of slot r_k-1.
                    if (r_k != 2'd3) begin
                        r_cand_row[r_k] <= nbr.row;
                        r_cand_col[r_k] <= nbr.col;
                        r_pend_in       <= nbr.in_img;
                    end
                    if (r_k != 2'd0) begin
                        r_cand_valid[r_k - 2'd1] <= r_pend_in && mem_rdata.obj;
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid   <= 1'b1;
                        o_cand0_row   <= r_cand_row[0];
                        o_cand0_col   <= r_cand_col[0];
                        o_cand0_valid <= r_cand_valid[0];
                        o_cand1_row   <= r_cand_row[1];
                        o_cand1_col   <= r_cand_col[1];
                        o_cand1_valid <= r_cand_valid[1];
                        o_cand2_row   <= r_cand_row[2];
                        o_cand2_col   <= r_cand_col[2];
                        o_cand2_valid <= r_cand_valid[2];
                        o_remove_flag <= |r_cand_valid;
                        o_visited_out <= r_vis_res;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/hrs_pixmem.sv =====
// Single-port pixel memory holding direction, object and visited bits per pixel.
`default_nettype none
module hrs_pixmem (
    input  wire logic             i_clk,
    input  wire hrs_pkg::t_mem_req i_req,
    output hrs_pkg::t_pix          o_rdata
);

    hrs_pkg::t_pix r_mem [hrs_pkg::DEPTH];
    hrs_pkg::t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end else begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/hrs_nbr.sv =====
// Cone lookup and neighbor position, bounds check and address for one cone slot.
`default_nettype none
module hrs_nbr (
    input  wire logic [hrs_pkg::COORD_W-1:0] i_row,
    input  wire logic [hrs_pkg::COORD_W-1:0] i_col,
    input  wire logic [hrs_pkg::DIR_W-1:0]   i_dir,
    input  wire logic [1:0]                  i_slot,
    input  wire logic [hrs_pkg::CONE_W-1:0]  i_cone_low,
    input  wire logic [hrs_pkg::CONE_W-1:0]  i_cone_high,
    input  wire logic [hrs_pkg::OFF_W-1:0]   i_offset,
    input  wire logic [hrs_pkg::COORD_W-1:0] i_rows,
    input  wire logic [hrs_pkg::COORD_W-1:0] i_cols,
    output hrs_pkg::t_nbr                    o_nbr
);

    logic [hrs_pkg::CONE_W-1:0]  tab;
    logic [8:0]                  entry;
    logic [hrs_pkg::DIR_W-1:0]   code;
    logic [3:0]                  steps;
    logic [hrs_pkg::COORD_W:0]   nr;
    logic [hrs_pkg::COORD_W:0]   nc;

    always_comb begin
        tab   = i_dir[2] ? i_cone_high : i_cone_low;
        entry = tab[i_dir[1:0]*9 +: 9];
        case (i_slot)
            2'd0:    code = entry[2:0];
            2'd1:    code = entry[5:3];
            2'd2:    code = entry[8:6];
            default: code = '0;
        endcase
        steps = i_offset[code*4 +: 4];
        // Steps are 2-bit two's complement; a negative result wraps high and fails the bounds.
        nr = {1'b0, i_row} + {{(hrs_pkg::COORD_W-1){steps[1]}}, steps[1:0]};
        nc = {1'b0, i_col} + {{(hrs_pkg::COORD_W-1){steps[3]}}, steps[3:2]};
        o_nbr.row    = nr[hrs_pkg::COORD_W-1:0];
        o_nbr.col    = nc[hrs_pkg::COORD_W-1:0];
        o_nbr.in_img = (nr != '0) && (nc != '0) &&
                       (nr <= {1'b0, i_rows}) && (nc <= {1'b0, i_cols});
        o_nbr.addr   = hrs_pkg::pix_addr(nr[hrs_pkg::COORD_W-1:0], nc[hrs_pkg::COORD_W-1:0]);
    end

endmodule
`default_nettype wire

// ===== hdl/hrs_check.sv =====
// Port-level checker for the region shrink step and its bind to the top level.
`default_nettype none
module hrs_check (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic [hrs_pkg::COORD_W-1:0]       o_cand0_row,
    input wire logic                              o_cand0_valid,
    input wire logic                              o_cand1_valid,
    input wire logic                              o_cand2_valid,
    input wire logic                              o_remove_flag,
    input wire logic                              o_visited_out
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled item dropped");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_remove_flag) && $stable(o_cand0_row))
        else $error("stalled item changed");

    a_remove_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_remove_flag == (o_cand0_valid || o_cand1_valid || o_cand2_valid))
        else $error("remove flag does not match candidates");

    a_remove_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_remove_flag |-> o_visited_out)
        else $error("removed pixel not marked visited");

endmodule

bind halo_region_shrink_step hrs_check u_hrs_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_cand0_row   (o_cand0_row),
    .o_cand0_valid (o_cand0_valid),
    .o_cand1_valid (o_cand1_valid),
    .o_cand2_valid (o_cand2_valid),
    .o_remove_flag (o_remove_flag),
    .o_visited_out (o_visited_out)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the halo region shrink step: directed and random pixel traffic against a predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrs_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int LONG_HOLD = 60;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIR_W-1:0]   dir;
        logic               obj;
        logic               vis;
    } t_pixel_cmd;

    typedef struct packed {
        logic [NCAND-1:0][COORD_W-1:0] crow;
        logic [NCAND-1:0][COORD_W-1:0] ccol;
        logic [NCAND-1:0]              cvalid;
        logic                          remove;
        logic                          visited;
    } t_shrink_result;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    t_pixel_cmd in_item = '0;

    logic o_in_stall, o_out_valid, o_cfg_ready;
    logic [COORD_W-1:0] o_cand0_row, o_cand0_col, o_cand1_row, o_cand1_col;
    logic [COORD_W-1:0] o_cand2_row, o_cand2_col;
    logic o_cand0_valid, o_cand1_valid, o_cand2_valid, o_remove_flag, o_visited_out;
    t_shrink_result seen;

    // Predictor copy of the registers and the pixel memory.
    logic [8:0]  rows_reg = 9'd256;
    logic [8:0]  cols_reg = 9'd256;
    logic [35:0] cone_lo_reg = '0;
    logic [35:0] cone_hi_reg = '0;
    logic [31:0] offset_reg = '0;
    bit [2:0] pix_dir [int];
    bit       pix_obj [int];
    bit       pix_vis [int];

    // Directions of the pixels that the generated traffic has loaded so far.
    bit [2:0] gen_dir [int];

    t_pixel_cmd     cmd_backlog[$];
    t_shrink_result due_results[$];
    bit  in_taken = 1'b0;
    bit  quiet = 1'b0;
    bit  long_hold_req = 1'b0;
    int  gap_left = 0;
    int  hold_left = 0;
    int  mismatches = 0;
    int  meaningful = 0;
    int  cycles = 0;

    halo_region_shrink_step dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (in_item.cmd),
        .i_row          (in_item.row),
        .i_col          (in_item.col),
        .i_direction_in (in_item.dir),
        .i_object_in    (in_item.obj),
        .i_visited_in   (in_item.vis),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_cand0_row    (o_cand0_row),
        .o_cand0_col    (o_cand0_col),
        .o_cand0_valid  (o_cand0_valid),
        .o_cand1_row    (o_cand1_row),
        .o_cand1_col    (o_cand1_col),
        .o_cand1_valid  (o_cand1_valid),
        .o_cand2_row    (o_cand2_row),
        .o_cand2_col    (o_cand2_col),
        .o_cand2_valid  (o_cand2_valid),
        .o_remove_flag  (o_remove_flag),
        .o_visited_out  (o_visited_out),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    assign seen = {o_cand2_row, o_cand1_row, o_cand0_row,
                   o_cand2_col, o_cand1_col, o_cand0_col,
                   o_cand2_valid, o_cand1_valid, o_cand0_valid,
                   o_remove_flag, o_visited_out};

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int rows_in_use();
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic int cols_in_use();
        return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic int pixel_slot(int r, int c);
        return (c - 1) * MAX_ROWS + (r - 1);
    endfunction

    function automatic bit in_memory(int r, int c);
        return r >= 1 && r <= MAX_ROWS && c >= 1 && c <= MAX_COLS;
    endfunction

    function automatic bit in_image(int r, int c);
        return r >= 1 && c >= 1 && r <= rows_in_use() && c <= cols_in_use();
    endfunction

    function automatic bit strictly_inside(int r, int c);
        return r > 1 && c > 1 && r < rows_in_use() && c < cols_in_use();
    endfunction

    // Row and column step of cone entry k for gradient code g.
    function automatic void cone_offset(input logic [2:0] g, input int k,
                                        output int dr, output int dc);
        logic [35:0] tab;
        logic [2:0]  code;
        logic [1:0]  rs;
        logic [1:0]  cs;
        tab  = g[2] ? cone_hi_reg : cone_lo_reg;
        code = tab[g[1:0] * 9 + k * 3 +: 3];
        rs   = offset_reg[code * 4 +: 2];
        cs   = offset_reg[code * 4 + 2 +: 2];
        dr   = int'($signed(rs));
        dc   = int'($signed(cs));
    endfunction

    function automatic t_shrink_result next_shrink_result(t_pixel_cmd it);
        t_shrink_result res;
        int r, c, nr, nc, dr, dc, a;
        logic [2:0] g;
        bit ok;
        res = '0;
        r = int'(it.row);
        c = int'(it.col);
        if (!in_memory(r, c) || it.cmd == CMD_UNUSED)
            return res;
        a = pixel_slot(r, c);
        if (it.cmd == CMD_LOAD) begin
            pix_dir[a] = it.dir;
            pix_obj[a] = it.obj;
            pix_vis[a] = it.vis;
        end else if (it.cmd == CMD_PROCESS) begin
            if (!pix_vis[a] && strictly_inside(r, c)) begin
                g = pix_dir[a];
                pix_vis[a] = 1'b1;
                for (int k = 0; k < NCAND; k++) begin
                    cone_offset(g, k, dr, dc);
                    nr = r + dr;
                    nc = c + dc;
                    // The object bit of a neighbor outside the image is never looked at.
                    ok = in_image(nr, nc) ? pix_obj[pixel_slot(nr, nc)] : 1'b0;
                    res.crow[k] = 9'(nr);
                    res.ccol[k] = 9'(nc);
                    res.cvalid[k] = ok;
                    if (ok)
                        res.remove = 1'b1;
                end
            end
        end
        res.visited = pix_vis[a];
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result checking first, then input acceptance and prediction.
    always @(posedge i_clk) begin
        t_shrink_result want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    for (int k = 0; k < NCAND; k++) begin
                        check_field($sformatf("cand%0d_row", k), 16'(want.crow[k]),
                                    16'(seen.crow[k]));
                        check_field($sformatf("cand%0d_col", k), 16'(want.ccol[k]),
                                    16'(seen.ccol[k]));
                        check_field($sformatf("cand%0d_valid", k), 16'(want.cvalid[k]),
                                    16'(seen.cvalid[k]));
                    end
                    check_field("remove_flag", 16'(want.remove), 16'(seen.remove));
                    check_field("visited_out", 16'(want.visited), 16'(seen.visited));
                end
            end
            if (in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                due_results.insert(due_results.size(), next_shrink_result(in_item));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sender: a valid item is held until taken; gaps only fall between items.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                in_item <= cmd_backlog.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 3);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stalls: short random bursts, plus one long hold on request.
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_ROWS: rows_reg = data[8:0];
            CFG_IMAGE_COLS: cols_reg = data[8:0];
            CFG_CONE_LOW:   cone_lo_reg = data[35:0];
            CFG_CONE_HIGH:  cone_hi_reg = data[35:0];
            CFG_OFFSET:     offset_reg = data[31:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [8:0] rows, input logic [8:0] cols,
                              input logic [35:0] lo, input logic [35:0] hi,
                              input logic [31:0] offs);
        write_reg(CFG_IMAGE_ROWS, 36'(rows));
        write_reg(CFG_IMAGE_COLS, 36'(cols));
        write_reg(CFG_CONE_LOW, lo);
        write_reg(CFG_CONE_HIGH, hi);
        write_reg(CFG_OFFSET, 36'(offs));
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
    endtask

    task automatic queue_item(logic [CMD_W-1:0] cmd, int r, int c,
                              logic [2:0] d, bit o, bit v);
        t_pixel_cmd it;
        it.cmd = cmd;
        it.row = 9'(r);
        it.col = 9'(c);
        it.dir = d;
        it.obj = o;
        it.vis = v;
        if (in_memory(r, c) && cmd != CMD_UNUSED)
            meaningful++;
        if (in_memory(r, c) && cmd == CMD_LOAD)
            gen_dir[pixel_slot(r, c)] = d;
        cmd_backlog.insert(cmd_backlog.size(), it);
    endtask

    // The memory is undefined until loaded, so every pixel read gets a load first.
    task automatic ensure_loaded(int r, int c);
        if (in_memory(r, c) && !gen_dir.exists(pixel_slot(r, c)))
            queue_item(CMD_LOAD, r, c, 3'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic queue_process(int r, int c);
        int dr, dc;
        ensure_loaded(r, c);
        if (strictly_inside(r, c)) begin
            for (int k = 0; k < NCAND; k++) begin
                cone_offset(gen_dir[pixel_slot(r, c)], k, dr, dc);
                if (in_image(r + dr, c + dc))
                    ensure_loaded(r + dr, c + dc);
            end
        end
        queue_item(CMD_PROCESS, r, c, 3'($urandom), 1'($urandom), 1'($urandom));
    endtask

    function automatic int pick_inner(int dim);
        case ($urandom_range(0, 3))
            0: return 2;
            1: return dim - 1;
            default: return $urandom_range(2, dim - 1);
        endcase
    endfunction

    function automatic int pick_any(int dim, int limit);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom_range(0, 1) ? 0 : int'($urandom_range(limit + 1, 511));
        if (sel == 1 && dim < limit)
            return $urandom_range(dim + 1, limit);
        if (sel == 2)
            return $urandom_range(0, 1) ? 1 : dim;
        return $urandom_range(1, dim);
    endfunction

    // Load a pixel and refresh some of its cone neighbors, then process it, at times again, and at times read it.
    task automatic shrink_sequence();
        int r, c, nr, nc, dr, dc;
        r = pick_inner(rows_in_use());
        c = pick_inner(cols_in_use());
        queue_item(CMD_LOAD, r, c, 3'($urandom), 1'($urandom), $urandom_range(0, 5) == 0);
        for (int k = 0; k < NCAND; k++) begin
            cone_offset(gen_dir[pixel_slot(r, c)], k, dr, dc);
            nr = r + dr;
            nc = c + dc;
            if (in_image(nr, nc) && !(nr == r && nc == c) &&
                (!gen_dir.exists(pixel_slot(nr, nc)) || $urandom_range(0, 1) == 1))
                queue_item(CMD_LOAD, nr, nc, 3'($urandom), $urandom_range(0, 3) != 0,
                           1'($urandom));
        end
        queue_process(r, c);
        if ($urandom_range(0, 2) == 0)
            queue_process(r, c);
        if ($urandom_range(0, 2) == 0)
            queue_item(CMD_READ, r, c, 3'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic noise_item();
        int r, c;
        r = pick_any(rows_in_use(), MAX_ROWS);
        c = pick_any(cols_in_use(), MAX_COLS);
        case ($urandom_range(0, 3))
            0: queue_item(CMD_LOAD, r, c, 3'($urandom), 1'($urandom), 1'($urandom));
            1: queue_process(r, c);
            2: begin
                ensure_loaded(r, c);
                queue_item(CMD_READ, r, c, 3'($urandom), 1'($urandom), 1'($urandom));
            end
            default: queue_item(CMD_UNUSED, r, c, 3'($urandom), 1'($urandom), 1'($urandom));
        endcase
    endtask

    task automatic shrink_phase(int n);
        int goal;
        goal = meaningful + n;
        while (meaningful < goal) begin
            if ($urandom_range(0, 9) < 7)
                shrink_sequence();
            else
                noise_item();
        end
    endtask

    // With the reset registers every cone points at the pixel itself.
    task automatic directed_items();
        queue_item(CMD_LOAD, 1, 1, 3'd0, 1'b1, 1'b0);
        queue_item(CMD_READ, 1, 1, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_PROCESS, 1, 1, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_LOAD, 256, 256, 3'd7, 1'b1, 1'b0);
        queue_item(CMD_PROCESS, 256, 256, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_READ, 256, 256, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_LOAD, 2, 2, 3'd7, 1'b1, 1'b0);
        queue_item(CMD_PROCESS, 2, 2, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_PROCESS, 2, 2, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_READ, 2, 2, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_LOAD, 255, 255, 3'd4, 1'b0, 1'b0);
        queue_item(CMD_PROCESS, 255, 255, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_LOAD, 100, 100, 3'd3, 1'b1, 1'b1);
        queue_item(CMD_PROCESS, 100, 100, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_LOAD, 0, 5, 3'd7, 1'b1, 1'b1);
        queue_item(CMD_PROCESS, 300, 5, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_READ, 5, 511, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_UNUSED, 2, 2, 3'd7, 1'b1, 1'b1);
        queue_item(CMD_LOAD, 257, 1, 3'd7, 1'b1, 1'b1);
        queue_item(CMD_READ, 1, 0, 3'd0, 1'b0, 1'b0);
        queue_item(CMD_LOAD, 255, 2, 3'd5, 1'b1, 1'b0);
        queue_item(CMD_PROCESS, 255, 2, 3'd0, 1'b0, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();
        drain();

        // Smallest image: only the center pixel can be processed.
        set_config(9'd3, 9'd3, 36'($urandom), 36'($urandom), $urandom);
        shrink_phase(40);
        drain();

        // Full image, extreme tables; the sender pauses halfway until all results are in.
        set_config(9'd256, 9'd256, 36'hF_FFFF_FFFF, 36'h0, 32'hFFFF_FFFF);
        shrink_phase(30);
        drain();
        shrink_phase(30);
        drain();

        // Oversized row count clamps to the memory; the receiver holds off for a while.
        set_config(9'd511, 9'd17, 36'({$urandom, $urandom}), 36'({$urandom, $urandom}),
                   32'hAAAA_AAAA);
        long_hold_req = 1'b1;
        shrink_phase(60);
        drain();

        set_config(9'd12, 9'd300, 36'({$urandom, $urandom}), 36'({$urandom, $urandom}),
                   $urandom);
        shrink_phase(50);
        drain();

        repeat (2) begin
            set_config(9'($urandom_range(3, 40)), 9'($urandom_range(3, 40)),
                       36'({$urandom, $urandom}), 36'({$urandom, $urandom}), $urandom);
            shrink_phase(60);
            drain();
        end

        quiet = 1'b1;
        set_config(9'($urandom_range(3, 256)), 9'($urandom_range(3, 256)),
                   36'({$urandom, $urandom}), 36'({$urandom, $urandom}), $urandom);
        shrink_phase(60);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
